[design/vector_heading_sector_quantizer_unit_macros.svh]
// assertion macros for the vector heading sector quantizer unit
`ifndef VECTOR_HEADING_SECTOR_QUANTIZER_UNIT_MACROS_SVH
`define VECTOR_HEADING_SECTOR_QUANTIZER_UNIT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, held off while reset is low
`define VHSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vhsq assertion failed");

// next-cycle implication, held off while reset is low
`define VHSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vhsq assertion failed");

`else

`define VHSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define VHSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/vhsq_pkg.sv]
// shared types, constants and functions of the heading sector quantizer
`default_nettype none

package vhsq_pkg;

    localparam int COMPONENT_WIDTH_DEF = 16;

    // tangent thresholds in unsigned q3.16
    localparam int K_WIDTH   = 19;
    localparam int FRAC_BITS = 16;
    localparam int K_COUNT   = 6;

    localparam int K_IDX_1_16 = 0;
    localparam int K_IDX_1_8  = 1;
    localparam int K_IDX_3_16 = 2;
    localparam int K_IDX_5_16 = 3;
    localparam int K_IDX_3_8  = 4;
    localparam int K_IDX_7_16 = 5;

    localparam logic [K_WIDTH-1:0] K_TAB [K_COUNT] = '{
        19'd13036,   // tan(pi/16)
        19'd27146,   // tan(pi/8)
        19'd43790,   // tan(3pi/16)
        19'd98082,   // tan(5pi/16)
        19'd158218,  // tan(3pi/8)
        19'd329472   // tan(7pi/16)
    };

    // 256*pi*2^20, rounded
    localparam int              RAD_PROD_W = 35;
    localparam logic [29:0]     RAD_SCALE  = 30'd843314857;
    localparam int              RAD_SHIFT  = 20;

    localparam int UNITS_W     = 6;
    localparam int RAD_W       = 16;
    localparam int UNITS_MAG_W = 5;
    localparam int RAD_MAG_W   = 15;

    typedef enum logic [1:0] {
        MODE_8  = 2'd0,
        MODE_16 = 2'd1,
        MODE_32 = 2'd2
    } t_sector_mode;

    typedef struct packed {
        logic         valid;
        logic         x_pos;
        logic         y_pos;
        t_sector_mode mode;
    } t_ctl;

    typedef struct packed {
        logic               a_lt_b;
        logic [K_COUNT-1:0] lt;
    } t_cmp;

    // sector centre in pi/32 units to radians * 8192, rounded to nearest
    function automatic logic [RAD_MAG_W-1:0] rad_of(input logic [UNITS_MAG_W-1:0] u);
        logic [RAD_PROD_W-1:0] p;
        p = RAD_PROD_W'(u) * RAD_PROD_W'(RAD_SCALE)
            + (RAD_PROD_W'(1) << (RAD_SHIFT - 1));
        return p[RAD_SHIFT +: RAD_MAG_W];
    endfunction

endpackage

`default_nettype wire

[design/vector_heading_sector_quantizer_unit.sv]
// top level of the vector heading sector quantizer
//
// usage
//   a word (i_x_value, i_y_value) is taken at a rising edge with start high
//   and busy low. busy is low whenever reset is released, so a new word can
//   be given every cycle.
//   each word gives exactly one result word on o_angle_units (pi/32 units)
//   and o_angle_radians (radians * 8192), shown for one cycle with o_strobe.
//   the receiver has no ready: it must take the result in that cycle.
// timing
//   four register stages (magnitude, constant products, compares, output).
//   a taken word passes through these registers in that order, and its result
//   shows with o_strobe from the output register. throughput is one word per
//   cycle, set by the six parallel constant multipliers of the product stage.
// configuration
//   i_cfg_we writes i_cfg_wdata into sector_mode (0: 8, 1: 16, 2 or 3: 32
//   sectors). each word carries the mode seen when it was taken.
// reset
//   synchronous, active low: pipeline valids clear, mode returns to 32
//   sectors, busy is high while reset is held.
`default_nettype none
`include "vector_heading_sector_quantizer_unit_macros.svh"

module vector_heading_sector_quantizer_unit #(
    parameter int COMPONENT_WIDTH = vhsq_pkg::COMPONENT_WIDTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic signed [COMPONENT_WIDTH-1:0]     i_x_value,
    input  wire logic signed [COMPONENT_WIDTH-1:0]     i_y_value,
    input  wire logic                                  i_cfg_we,
    input  wire logic [1:0]                            i_cfg_wdata,
    output logic                                       o_strobe,
    output logic signed [vhsq_pkg::UNITS_W-1:0]        o_angle_units,
    output logic signed [vhsq_pkg::RAD_W-1:0]          o_angle_radians
);

    vhsq_pkg::t_sector_mode     r_sector_mode;
    logic                       accept;
    vhsq_pkg::t_ctl             mag_ctl, cmp_ctl;
    vhsq_pkg::t_cmp             cmp_bits;
    logic [COMPONENT_WIDTH-1:0] mag_a, mag_b;

    // nothing holds the pipeline, only reset keeps words out
    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_mode <= vhsq_pkg::MODE_32;
        end else if (i_cfg_we) begin
            r_sector_mode <= vhsq_pkg::t_sector_mode'(i_cfg_wdata);
        end
    end

    // stage 1: signs and magnitudes
    vhsq_mag #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_mode  (r_sector_mode),
        .i_x     (i_x_value),
        .i_y     (i_y_value),
        .o_ctl   (mag_ctl),
        .o_mag_a (mag_a),
        .o_mag_b (mag_b)
    );

    // stages 2 and 3: k*|x| products, then compares against |y|
    vhsq_cmp #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mag_ctl),
        .i_mag_a (mag_a),
        .i_mag_b (mag_b),
        .o_ctl   (cmp_ctl),
        .o_cmp   (cmp_bits)
    );

    // stage 4: sector centre, radians, sign
    vhsq_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (cmp_ctl),
        .i_cmp           (cmp_bits),
        .o_strobe        (o_strobe),
        .o_angle_units   (o_angle_units),
        .o_angle_radians (o_angle_radians)
    );

    // every taken word comes out with o_strobe
    `VHSQ_ASSERT_NEXT(a_latency, i_clk, i_rst_n, accept, ##3 o_strobe)
    // no result without a word taken before it
    `VHSQ_ASSERT_IMPL(a_no_ghost, i_clk, i_rst_n, o_strobe, $past(accept, 4))
    // units and radians carry the same sign
    `VHSQ_ASSERT_IMPL(a_sign_match, i_clk, i_rst_n, o_strobe,
        o_angle_units[vhsq_pkg::UNITS_W-1] == o_angle_radians[vhsq_pkg::RAD_W-1])
    // 32-sector centres are odd multiples of pi/32
    `VHSQ_ASSERT_IMPL(a_odd_32, i_clk, i_rst_n,
        o_strobe && ($past(r_sector_mode, 4) == vhsq_pkg::MODE_32), o_angle_units[0])

endmodule

`default_nettype wire

[design/vhsq_mag.sv]
// input stage: component signs and magnitudes
`default_nettype none

module vhsq_mag #(
    parameter int COMPONENT_WIDTH = vhsq_pkg::COMPONENT_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire vhsq_pkg::t_sector_mode            i_mode,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_y,
    output vhsq_pkg::t_ctl                         o_ctl,
    output logic [COMPONENT_WIDTH-1:0]             o_mag_a,
    output logic [COMPONENT_WIDTH-1:0]             o_mag_b
);

    vhsq_pkg::t_ctl             r_ctl, n_ctl;
    logic [COMPONENT_WIDTH-1:0] r_mag_a, n_mag_a;
    logic [COMPONENT_WIDTH-1:0] r_mag_b, n_mag_b;

    // zero counts as not positive; most negative value keeps its full magnitude
    always_comb begin
        n_ctl.valid = i_valid;
        n_ctl.mode  = i_mode;
        n_ctl.x_pos = !i_x[COMPONENT_WIDTH-1] && (i_x != '0);
        n_ctl.y_pos = !i_y[COMPONENT_WIDTH-1] && (i_y != '0);
        n_mag_a     = i_x[COMPONENT_WIDTH-1] ? (~i_x + 1'b1) : i_x;
        n_mag_b     = i_y[COMPONENT_WIDTH-1] ? (~i_y + 1'b1) : i_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= n_ctl.valid;
        end
        r_ctl.x_pos <= n_ctl.x_pos;
        r_ctl.y_pos <= n_ctl.y_pos;
        r_ctl.mode  <= n_ctl.mode;
        r_mag_a     <= n_mag_a;
        r_mag_b     <= n_mag_b;
    end

    assign o_ctl   = r_ctl;
    assign o_mag_a = r_mag_a;
    assign o_mag_b = r_mag_b;

endmodule

`default_nettype wire

[design/vhsq_cmp.sv]
// threshold stages: constant products, then strict compares
`default_nettype none

module vhsq_cmp #(
    parameter int COMPONENT_WIDTH = vhsq_pkg::COMPONENT_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire vhsq_pkg::t_ctl        i_ctl,
    input  wire logic [COMPONENT_WIDTH-1:0] i_mag_a,
    input  wire logic [COMPONENT_WIDTH-1:0] i_mag_b,
    output vhsq_pkg::t_ctl             o_ctl,
    output vhsq_pkg::t_cmp             o_cmp
);

    localparam int PW = COMPONENT_WIDTH + vhsq_pkg::K_WIDTH;

    // product stage
    vhsq_pkg::t_ctl             r_ctl_p;
    logic [PW-1:0]              r_prod [vhsq_pkg::K_COUNT];
    logic [PW-1:0]              n_prod [vhsq_pkg::K_COUNT];
    logic [COMPONENT_WIDTH-1:0] r_mag_a, r_mag_b;

    // compare stage
    vhsq_pkg::t_ctl r_ctl_c;
    vhsq_pkg::t_cmp r_cmp, n_cmp;
    logic [PW-1:0]  b_shift;

    always_comb begin
        for (int i = 0; i < vhsq_pkg::K_COUNT; i++) begin
            n_prod[i] = PW'(i_mag_a) * PW'(vhsq_pkg::K_TAB[i]);
        end
    end

    // k*|x| < |y|*2^16, exact at full width
    always_comb begin
        b_shift      = PW'(r_mag_b) << vhsq_pkg::FRAC_BITS;
        n_cmp.a_lt_b = r_mag_a < r_mag_b;
        for (int i = 0; i < vhsq_pkg::K_COUNT; i++) begin
            n_cmp.lt[i] = r_prod[i] < b_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_p.valid <= 1'b0;
            r_ctl_c.valid <= 1'b0;
        end else begin
            r_ctl_p.valid <= i_ctl.valid;
            r_ctl_c.valid <= r_ctl_p.valid;
        end
        r_ctl_p.x_pos <= i_ctl.x_pos;
        r_ctl_p.y_pos <= i_ctl.y_pos;
        r_ctl_p.mode  <= i_ctl.mode;
        r_mag_a       <= i_mag_a;
        r_mag_b       <= i_mag_b;
        r_prod        <= n_prod;
        r_ctl_c.x_pos <= r_ctl_p.x_pos;
        r_ctl_c.y_pos <= r_ctl_p.y_pos;
        r_ctl_c.mode  <= r_ctl_p.mode;
        r_cmp         <= n_cmp;
    end

    assign o_ctl = r_ctl_c;
    assign o_cmp = r_cmp;

endmodule

`default_nettype wire

[design/vhsq_out.sv]
// output stage: sector pick, quadrant fold, radians and sign
`default_nettype none

module vhsq_out (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire vhsq_pkg::t_ctl                         i_ctl,
    input  wire vhsq_pkg::t_cmp                         i_cmp,
    output logic                                        o_strobe,
    output logic signed [vhsq_pkg::UNITS_W-1:0]         o_angle_units,
    output logic signed [vhsq_pkg::RAD_W-1:0]           o_angle_radians
);

    logic                                r_strobe;
    logic [vhsq_pkg::UNITS_W-1:0]        r_units, n_units;
    logic [vhsq_pkg::RAD_W-1:0]          r_rad, n_rad;
    logic [vhsq_pkg::UNITS_MAG_W-1:0]    q_units;
    logic [vhsq_pkg::UNITS_MAG_W-1:0]    f_units;
    logic [vhsq_pkg::RAD_MAG_W-1:0]      rad_mag;

    // first-quadrant sector centre in pi/32 units
    always_comb begin
        case (i_ctl.mode)
            vhsq_pkg::MODE_8: begin
                q_units = i_cmp.a_lt_b ? 5'd12 : 5'd4;
            end
            vhsq_pkg::MODE_16: begin
                if (i_cmp.a_lt_b) begin
                    q_units = i_cmp.lt[vhsq_pkg::K_IDX_3_8] ? 5'd14 : 5'd10;
                end else begin
                    q_units = i_cmp.lt[vhsq_pkg::K_IDX_1_8] ? 5'd6 : 5'd2;
                end
            end
            default: begin
                // 32 sectors, unused mode code included
                if (i_cmp.a_lt_b) begin
                    if (i_cmp.lt[vhsq_pkg::K_IDX_3_8]) begin
                        q_units = i_cmp.lt[vhsq_pkg::K_IDX_7_16] ? 5'd15 : 5'd13;
                    end else begin
                        q_units = i_cmp.lt[vhsq_pkg::K_IDX_5_16] ? 5'd11 : 5'd9;
                    end
                end else begin
                    if (i_cmp.lt[vhsq_pkg::K_IDX_1_8]) begin
                        q_units = i_cmp.lt[vhsq_pkg::K_IDX_3_16] ? 5'd7 : 5'd5;
                    end else begin
                        q_units = i_cmp.lt[vhsq_pkg::K_IDX_1_16] ? 5'd3 : 5'd1;
                    end
                end
            end
        endcase
    end

    // mirror into the left half, then sign from y
    always_comb begin
        f_units = i_ctl.x_pos ? q_units : (5'd0 - q_units);
        rad_mag = vhsq_pkg::rad_of(f_units);
        n_units = i_ctl.y_pos ? {1'b0, f_units} : (~{1'b0, f_units} + 1'b1);
        n_rad   = i_ctl.y_pos ? {1'b0, rad_mag} : (~{1'b0, rad_mag} + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_ctl.valid;
        end
        r_units <= n_units;
        r_rad   <= n_rad;
    end

    assign o_strobe        = r_strobe;
    assign o_angle_units   = r_units;
    assign o_angle_radians = r_rad;

endmodule

`default_nettype wire
